// File: src/bfpa_pkg.sv
`default_nettype none
package bfpa_pkg;

  // chunk granularity: sizes are multiples of 16 bytes
  localparam int unsigned AlignShift = 4;
  // upstream addresses end at 2^32
  localparam logic [33:0] AddrLimit = 34'h1_0000_0000;

  // register indexes on the config port
  localparam logic [1:0] REG_INIT_BLOCK = 2'd0;
  localparam logic [1:0] REG_MIN_BLOCK  = 2'd1;
  localparam logic [1:0] REG_CAPACITY   = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_UPSTREAM   = 2'd1;
  localparam logic [1:0] STAT_TABLE_FULL = 2'd2;
  localparam logic [1:0] STAT_UNKNOWN    = 2'd3;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LATCH, CMD_INIT, CMD_SCAN, CMD_TAKE, CMD_NEWBLK, CMD_SPLIT,
    CMD_LINK, CMD_ADONE, CMD_FAIL, CMD_FREE0, CMD_FREE1, CMD_FREE2, CMD_OUT
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SCAN, S_DECIDE, S_TAKE, S_NEWBLK, S_SPLIT, S_LINK,
    S_ADONE, S_FREE0, S_FREE1, S_FREE2, S_OUT
  } state_e;

  typedef struct packed {
    cmd_e       op;
    logic [1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic started;
    logic op_free;
    logic scan_done;
    logic match;
    logic found;
    logic found_split;
    logic fits;
    logic e1_ok;
    logic e2_ok;
    logic blk_split;
  } dp_stat_t;

  // round up to the chunk granularity, zero rounds to one granule
  function automatic logic [32:0] round_up(input logic [31:0] n);
    logic [32:0] s;
    s = {1'b0, n} + 33'd15;
    if (n == 32'd0) begin
      return 33'd16;
    end
    return (s >> AlignShift) << AlignShift;
  endfunction

  // upstream region check for a block of blk bytes at the bump pointer
  function automatic logic upstream_fits(input logic [31:0] bump, input logic [32:0] blk,
                                         input logic [31:0] cap);
    logic [33:0] e;
    e = {2'b00, bump} + {1'b0, blk};
    return (e <= {2'b00, cap}) && (e <= AddrLimit);
  endfunction

endpackage
`default_nettype wire

// File: src/bfpa_ctrl.sv
`default_nettype none
module bfpa_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  wire bfpa_pkg::dp_stat_t stat_i,
  output bfpa_pkg::dp_cmd_t   cmd_o
);
  import bfpa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = stat_i.started ? S_SCAN : S_INIT;
        end
      end
      S_INIT: state_d = S_SCAN;
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.op_free) begin
          state_d = stat_i.match ? S_FREE0 : S_OUT;
        end else if (stat_i.found) begin
          state_d = (stat_i.found_split && !stat_i.e1_ok) ? S_OUT : S_TAKE;
        end else if (!stat_i.fits || !stat_i.e1_ok ||
                     (stat_i.blk_split && !stat_i.e2_ok)) begin
          state_d = S_OUT;
        end else begin
          state_d = S_NEWBLK;
        end
      end
      S_TAKE:   state_d = stat_i.found_split ? S_SPLIT : S_ADONE;
      S_NEWBLK: state_d = stat_i.blk_split ? S_SPLIT : S_ADONE;
      S_SPLIT:  state_d = S_LINK;
      S_LINK:   state_d = S_ADONE;
      S_ADONE:  state_d = S_OUT;
      S_FREE0:  state_d = S_FREE1;
      S_FREE1:  state_d = S_FREE2;
      S_FREE2:  state_d = S_OUT;
      S_OUT:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.op   = CMD_NONE;
    cmd_o.code = STAT_OK;
    case (state_q)
      S_IDLE:   if (start) cmd_o.op = CMD_LATCH;
      S_INIT:   cmd_o.op = CMD_INIT;
      S_SCAN:   cmd_o.op = CMD_SCAN;
      S_DECIDE: begin
        if (stat_i.op_free) begin
          if (!stat_i.match) begin
            cmd_o.op   = CMD_FAIL;
            cmd_o.code = STAT_UNKNOWN;
          end
        end else if (stat_i.found) begin
          if (stat_i.found_split && !stat_i.e1_ok) begin
            cmd_o.op   = CMD_FAIL;
            cmd_o.code = STAT_TABLE_FULL;
          end
        end else if (!stat_i.fits) begin
          cmd_o.op   = CMD_FAIL;
          cmd_o.code = STAT_UPSTREAM;
        end else if (!stat_i.e1_ok || (stat_i.blk_split && !stat_i.e2_ok)) begin
          cmd_o.op   = CMD_FAIL;
          cmd_o.code = STAT_TABLE_FULL;
        end
      end
      S_TAKE:   cmd_o.op = CMD_TAKE;
      S_NEWBLK: cmd_o.op = CMD_NEWBLK;
      S_SPLIT:  cmd_o.op = CMD_SPLIT;
      S_LINK:   cmd_o.op = CMD_LINK;
      S_ADONE:  cmd_o.op = CMD_ADONE;
      S_FREE0:  cmd_o.op = CMD_FREE0;
      S_FREE1:  cmd_o.op = CMD_FREE1;
      S_FREE2:  cmd_o.op = CMD_FREE2;
      S_OUT:    cmd_o.op = CMD_OUT;
      default:  cmd_o.op = CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

// File: src/bfpa_dp.sv
`default_nettype none
module bfpa_dp #(
  parameter int unsigned CHUNK_ENTRIES = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire  [31:0]        init_block_i,
  input  wire  [31:0]        min_block_i,
  input  wire  [31:0]        capacity_i,
  input  wire                operation_i,
  input  wire  [31:0]        request_bytes_i,
  input  wire  [31:0]        free_address_i,
  input  wire bfpa_pkg::dp_cmd_t cmd_i,
  output bfpa_pkg::dp_stat_t stat_o,
  output logic               done_o,
  output logic [31:0]        granted_address_o,
  output logic [1:0]         status_o,
  output logic [31:0]        bytes_in_use_o,
  output logic [31:0]        bytes_from_upstream_o
);
  import bfpa_pkg::*;

  localparam int unsigned IW = (CHUNK_ENTRIES > 1) ? $clog2(CHUNK_ENTRIES) : 1;
  localparam int unsigned LW = $clog2(CHUNK_ENTRIES + 1);
  localparam logic [LW-1:0] NoLink = LW'(CHUNK_ENTRIES);

  // chunk table storage
  logic [31:0]   base_mem  [CHUNK_ENTRIES];
  logic [31:0]   size_mem  [CHUNK_ENTRIES];
  logic [LW-1:0] prev_mem  [CHUNK_ENTRIES];
  logic [LW-1:0] next_mem  [CHUNK_ENTRIES];
  logic [31:0]   order_mem [CHUNK_ENTRIES];

  logic [CHUNK_ENTRIES-1:0] valid_q, free_q;

  // request and bookkeeping
  logic          op_q, started_q;
  logic [32:0]   need_q;
  logic [31:0]   faddr_q;
  logic [31:0]   counter_q, bump_q, in_use_q, upstream_q;

  // scan pipeline
  logic [LW-1:0] sc_q;
  logic          rd_v_q;
  logic [IW-1:0] rd_idx_q;
  logic [31:0]   rd_base_q, rd_size_q, rd_order_q;
  logic [LW-1:0] rd_prev_q, rd_next_q;
  logic [IW-1:0] raddr;

  // best candidate and empty slots
  logic          found_q, match_q, e1v_q, e2v_q;
  logic [IW-1:0] bidx_q, e1_q, e2_q;
  logic [31:0]   bsize_q, border_q, bbase_q;
  logic [LW-1:0] bnext_q;

  // current chunk
  logic [IW-1:0] c_q, s2_q;
  logic [31:0]   cbase_q, csize_q;
  logic [LW-1:0] cprev_q, cnext_q;

  // result
  logic          done_q;
  logic [31:0]   res_addr_q, res_use_q, res_up_q;
  logic [1:0]    res_stat_q;

  // derived values
  logic [32:0] iblk, mblk, blk;
  logic        ifits, fits;
  logic        pm, nm;
  logic [IW-1:0] pidx, nidx;
  logic [31:0] psum;

  assign iblk  = round_up(init_block_i);
  assign mblk  = round_up(min_block_i);
  assign blk   = (need_q > mblk) ? need_q : mblk;
  assign ifits = upstream_fits(bump_q, iblk, capacity_i);
  assign fits  = upstream_fits(bump_q, blk, capacity_i);

  assign pidx = cprev_q[IW-1:0];
  assign nidx = cnext_q[IW-1:0];
  assign pm   = (cprev_q < NoLink) && valid_q[pidx] && free_q[pidx];
  assign nm   = (cnext_q < NoLink) && valid_q[nidx] && free_q[nidx];
  assign psum = rd_size_q + csize_q;

  assign stat_o.started     = started_q;
  assign stat_o.op_free     = (op_q == OP_FREE);
  assign stat_o.scan_done   = (sc_q == NoLink) && !rd_v_q;
  assign stat_o.match       = match_q;
  assign stat_o.found       = found_q;
  assign stat_o.found_split = ({1'b0, bsize_q} != need_q);
  assign stat_o.fits        = fits;
  assign stat_o.e1_ok       = e1v_q;
  assign stat_o.e2_ok       = e2v_q;
  assign stat_o.blk_split   = (blk != need_q);

  // read address of the shared table port
  always_comb begin
    raddr = '0;
    case (cmd_i.op)
      CMD_SCAN:  if (sc_q < NoLink) raddr = sc_q[IW-1:0];
      CMD_FREE0: if (cprev_q < NoLink) raddr = pidx;
      CMD_FREE1: if (cnext_q < NoLink) raddr = nidx;
      default:   raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_base_q  <= base_mem[raddr];
    rd_size_q  <= size_mem[raddr];
    rd_prev_q  <= prev_mem[raddr];
    rd_next_q  <= next_mem[raddr];
    rd_order_q <= order_mem[raddr];
  end

  // write ports, one per field array
  logic          we_base, we_size, we_prev, we_next, we_order;
  logic [IW-1:0] wa_base, wa_size, wa_prev, wa_next, wa_order;
  logic [31:0]   wd_base, wd_size, wd_order;
  logic [LW-1:0] wd_prev, wd_next;

  always_comb begin
    we_base = 1'b0; we_size = 1'b0; we_prev = 1'b0; we_next = 1'b0; we_order = 1'b0;
    wa_base = '0; wa_size = '0; wa_prev = '0; wa_next = '0; wa_order = '0;
    wd_base = '0; wd_size = '0; wd_order = '0; wd_prev = NoLink; wd_next = NoLink;
    case (cmd_i.op)
      CMD_INIT: begin
        if (!started_q && ifits) begin
          {we_base, we_size, we_prev, we_next, we_order} = 5'b11111;
          wd_base  = bump_q;
          wd_size  = iblk[31:0];
          wd_order = counter_q;
        end
      end
      CMD_NEWBLK: begin
        {we_base, we_size, we_prev, we_next, we_order} = 5'b11111;
        {wa_base, wa_size, wa_prev, wa_next, wa_order} = {5{e1_q}};
        wd_base = bump_q;
        wd_size = blk[31:0];
      end
      CMD_SPLIT: begin
        {we_base, we_size, we_prev, we_next, we_order} = 5'b11111;
        {wa_base, wa_size, wa_prev, wa_next, wa_order} = {5{s2_q}};
        wd_base  = cbase_q + need_q[31:0];
        wd_size  = csize_q - need_q[31:0];
        wd_prev  = LW'(c_q);
        wd_next  = cnext_q;
        wd_order = counter_q;
      end
      CMD_LINK: begin
        we_size = 1'b1; wa_size = c_q; wd_size = need_q[31:0];
        we_next = 1'b1; wa_next = c_q; wd_next = LW'(s2_q);
        we_prev = (cnext_q < NoLink); wa_prev = nidx; wd_prev = LW'(s2_q);
      end
      CMD_FREE1: begin
        // merge into the lower neighbor
        if (pm) begin
          we_size = 1'b1; wa_size = pidx; wd_size = psum;
          we_next = 1'b1; wa_next = pidx; wd_next = cnext_q;
          we_prev = (cnext_q < NoLink); wa_prev = nidx; wd_prev = cprev_q;
        end
      end
      CMD_FREE2: begin
        // absorb the upper neighbor, then stamp the free order
        if (nm) begin
          we_size = 1'b1; wa_size = c_q; wd_size = psum;
          we_next = 1'b1; wa_next = c_q; wd_next = rd_next_q;
          we_prev = (rd_next_q < NoLink); wa_prev = rd_next_q[IW-1:0];
          wd_prev = LW'(c_q);
        end
        we_order = 1'b1; wa_order = c_q; wd_order = counter_q;
      end
      default: we_base = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_base)  base_mem[wa_base]   <= wd_base;
    if (we_size)  size_mem[wa_size]   <= wd_size;
    if (we_prev)  prev_mem[wa_prev]   <= wd_prev;
    if (we_next)  next_mem[wa_next]   <= wd_next;
    if (we_order) order_mem[wa_order] <= wd_order;
  end

  // scan evaluation of the word read last cycle
  logic ev_fit, ev_better, ev_match;
  assign ev_fit = rd_v_q && valid_q[rd_idx_q] && free_q[rd_idx_q] &&
                  ({1'b0, rd_size_q} >= need_q);
  assign ev_better = !found_q || (rd_size_q < bsize_q) ||
                     ((rd_size_q == bsize_q) && (rd_order_q < border_q));
  assign ev_match = rd_v_q && (op_q == OP_FREE) && !match_q && valid_q[rd_idx_q] &&
                    !free_q[rd_idx_q] && (rd_base_q == faddr_q);

  // control and bookkeeping registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      free_q     <= '0;
      started_q  <= 1'b0;
      counter_q  <= '0;
      bump_q     <= '0;
      in_use_q   <= '0;
      upstream_q <= '0;
      sc_q       <= '0;
      rd_v_q     <= 1'b0;
      found_q    <= 1'b0;
      match_q    <= 1'b0;
      e1v_q      <= 1'b0;
      e2v_q      <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (cmd_i.op)
        CMD_LATCH: begin
          sc_q    <= '0;
          rd_v_q  <= 1'b0;
          found_q <= 1'b0;
          match_q <= 1'b0;
          e1v_q   <= 1'b0;
          e2v_q   <= 1'b0;
        end
        CMD_INIT: begin
          started_q <= 1'b1;
          if (ifits) begin
            valid_q[0] <= 1'b1;
            free_q[0]  <= 1'b1;
            counter_q  <= counter_q + 32'd1;
            bump_q     <= bump_q + iblk[31:0];
            upstream_q <= upstream_q + iblk[31:0];
          end
        end
        CMD_SCAN: begin
          rd_v_q <= (sc_q < NoLink);
          if (sc_q < NoLink) sc_q <= sc_q + LW'(1);
          if (ev_fit && ev_better) found_q <= 1'b1;
          if (ev_match) match_q <= 1'b1;
          if (rd_v_q && !valid_q[rd_idx_q]) begin
            if (!e1v_q) e1v_q <= 1'b1;
            else if (!e2v_q) e2v_q <= 1'b1;
          end
        end
        CMD_TAKE: free_q[bidx_q] <= 1'b0;
        CMD_NEWBLK: begin
          valid_q[e1_q] <= 1'b1;
          free_q[e1_q]  <= 1'b0;
          bump_q        <= bump_q + blk[31:0];
          upstream_q    <= upstream_q + blk[31:0];
        end
        CMD_SPLIT: begin
          valid_q[s2_q] <= 1'b1;
          free_q[s2_q]  <= 1'b1;
          counter_q     <= counter_q + 32'd1;
        end
        CMD_ADONE: in_use_q <= in_use_q + need_q[31:0];
        CMD_FREE0: begin
          in_use_q    <= in_use_q - csize_q;
          free_q[c_q] <= 1'b1;
        end
        CMD_FREE1: if (pm) valid_q[c_q] <= 1'b0;
        CMD_FREE2: begin
          if (nm) valid_q[nidx] <= 1'b0;
          counter_q <= counter_q + 32'd1;
        end
        CMD_OUT: done_q <= 1'b1;
        default: done_q <= 1'b0;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= sc_q[IW-1:0];
    case (cmd_i.op)
      CMD_LATCH: begin
        op_q    <= operation_i;
        need_q  <= round_up(request_bytes_i);
        faddr_q <= free_address_i;
      end
      CMD_SCAN: begin
        if (ev_fit && ev_better) begin
          bidx_q   <= rd_idx_q;
          bsize_q  <= rd_size_q;
          border_q <= rd_order_q;
          bbase_q  <= rd_base_q;
          bnext_q  <= rd_next_q;
        end
        if (ev_match) begin
          c_q     <= rd_idx_q;
          cbase_q <= rd_base_q;
          csize_q <= rd_size_q;
          cprev_q <= rd_prev_q;
          cnext_q <= rd_next_q;
        end
        if (rd_v_q && !valid_q[rd_idx_q]) begin
          if (!e1v_q) e1_q <= rd_idx_q;
          else if (!e2v_q) e2_q <= rd_idx_q;
        end
      end
      CMD_TAKE: begin
        c_q     <= bidx_q;
        cbase_q <= bbase_q;
        csize_q <= bsize_q;
        cnext_q <= bnext_q;
        s2_q    <= e1_q;
      end
      CMD_NEWBLK: begin
        c_q     <= e1_q;
        cbase_q <= bump_q;
        csize_q <= blk[31:0];
        cnext_q <= NoLink;
        s2_q    <= e2_q;
      end
      CMD_ADONE: begin
        res_addr_q <= cbase_q;
        res_stat_q <= STAT_OK;
      end
      CMD_FAIL: begin
        res_addr_q <= '0;
        res_stat_q <= cmd_i.code;
      end
      CMD_FREE1: begin
        if (pm) begin
          c_q     <= pidx;
          csize_q <= psum;
        end
      end
      CMD_FREE2: begin
        res_addr_q <= '0;
        res_stat_q <= STAT_OK;
      end
      CMD_OUT: begin
        res_use_q <= in_use_q;
        res_up_q  <= upstream_q;
      end
      default: res_stat_q <= res_stat_q;
    endcase
  end

  assign done_o                = done_q;
  assign granted_address_o     = res_addr_q;
  assign status_o              = res_stat_q;
  assign bytes_in_use_o        = res_use_q;
  assign bytes_from_upstream_o = res_up_q;

endmodule
`default_nettype wire

// File: src/best_fit_pool_allocator_unit.sv
`default_nettype none
// Best-fit pool allocator. Pulse start while busy is low to hand in one
// allocate or free; busy stays high until the result word appears on the
// result ports for exactly one cycle with done_o high. The receiver cannot
// stall: capture the word in that cycle. Every request walks the whole chunk
// table through its single read port; the first word after reset also
// creates the initial block. Configure only while idle.
module best_fit_pool_allocator_unit #(
  parameter int unsigned CHUNK_ENTRIES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         start,
  output logic        busy,
  input  wire         operation_i,
  input  wire  [31:0] request_bytes_i,
  input  wire  [31:0] free_address_i,
  output logic        done_o,
  output logic [31:0] granted_address_o,
  output logic [1:0]  status_o,
  output logic [31:0] bytes_in_use_o,
  output logic [31:0] bytes_from_upstream_o
);
  import bfpa_pkg::*;

  logic [31:0] init_block_q, min_block_q, capacity_q;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_block_q <= 32'd65536;
      min_block_q  <= 32'd4096;
      capacity_q   <= 32'hFFFF_FFFF;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_INIT_BLOCK: init_block_q <= pwdata;
        REG_MIN_BLOCK:  min_block_q  <= pwdata;
        REG_CAPACITY:   capacity_q   <= pwdata;
        default:        capacity_q   <= capacity_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INIT_BLOCK: prdata = init_block_q;
      REG_MIN_BLOCK:  prdata = min_block_q;
      REG_CAPACITY:   prdata = capacity_q;
      default:        prdata = '0;
    endcase
  end

  bfpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bfpa_dp #(
    .CHUNK_ENTRIES(CHUNK_ENTRIES)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .init_block_i          (init_block_q),
    .min_block_i           (min_block_q),
    .capacity_i            (capacity_q),
    .operation_i           (operation_i),
    .request_bytes_i       (request_bytes_i),
    .free_address_i        (free_address_i),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .done_o                (done_o),
    .granted_address_o     (granted_address_o),
    .status_o              (status_o),
    .bytes_in_use_o        (bytes_in_use_o),
    .bytes_from_upstream_o (bytes_from_upstream_o)
  );

endmodule
`default_nettype wire
